/* hdl/bfip_pkg.sv */
// ----------------------------------------------------------------------------
// bfip_pkg
// Shared constants, types and hash table for the Bloom filter insert/probe
// block.
// ----------------------------------------------------------------------------
package bfip_pkg;

  localparam int FILTER_WORDS = 2048;
  localparam int MAX_HASHES   = 16;
  localparam int PRIME_COUNT  = 15;

  localparam int KEY_W      = 32;
  localparam int WORD_W     = 32;
  localparam int BIT_SEL_W  = 5;
  localparam int CFG_BITS_W = 17;
  localparam int CFG_HASH_W = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 40;

  localparam int LIMIT   = FILTER_WORDS * WORD_W;
  localparam int ADDR_W  = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
  localparam int REM_W   = $clog2(LIMIT);
  localparam int MOD_W   = REM_W + 1;
  localparam int CMP_W   = (MOD_W > CFG_BITS_W) ? MOD_W : CFG_BITS_W;
  localparam int HIDX_W  = $clog2(MAX_HASHES + 1);
  localparam int PIDX_W  = $clog2(PRIME_COUNT);
  localparam int PRIME_W = 7;

  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = KEY_W / DIV_RADIX_BITS;
  localparam int STEP_W         = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES  = CFG_IDX_W'(1);

  localparam logic [CFG_BITS_W-1:0] FILTER_BITS_RST = CFG_BITS_W'(65536);
  localparam logic [CFG_HASH_W-1:0] NUM_HASHES_RST  = CFG_HASH_W'(8);

  typedef logic [PRIME_W-1:0] prime_t;

  localparam prime_t PRIMES [PRIME_COUNT] = '{
    7'd23, 7'd29, 7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53,
    7'd59, 7'd61, 7'd67, 7'd71, 7'd73, 7'd79, 7'd83
  };

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_PROBE  = 1'b1
  } cmd_t;

endpackage

/* hdl/bfip_ram.sv */
// ----------------------------------------------------------------------------
// bfip_ram
// Generic single-write, single-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module bfip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/bloom_filter_insert_probe_top.sv */
// ----------------------------------------------------------------------------
// bloom_filter_insert_probe_top
// Bloom filter over a 2048 x 32 bit store: insert or probe one key a request.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid / s_tready  tdata key, tuser command, tlast batch end
//   m_*      out  m_tvalid / m_tready  tdata key + hit, tlast batch end
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each hash runs multiply, shift, 8 remainder steps of 4 bits, memory read,
// then check or write back. A request occupies the block while it runs k hashes,
// k = num_hashes, or fewer when a probe meets a clear bit. The remainder unit
// and the single RAM port set the time a request takes. After reset a clearing
// pass writes all 2048 words with s_tready low. cfg_ready is always high. A
// waiting result does not block the next request; a finished request holds
// only while the output register is full and m_tready is low.
// ----------------------------------------------------------------------------
module bloom_filter_insert_probe_top
  import bfip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [31:0] key
  input  logic                   s_tlast,   // batch_end
  input  logic                   s_tuser,   // command
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [31:0] key_out, [32] hit, rest 0
  output logic                   m_tlast,   // batch_end_out
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_SHIFT,
    S_DIV,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_cnt;
  logic [MOD_W-1:0]  mod_eff;
  logic [HIDX_W-1:0] nh_eff;
  logic [KEY_W-1:0]  key_r;
  cmd_t              cmd_r;
  logic              last_r;
  logic              all_set;
  logic [HIDX_W-1:0] hidx;
  logic [PIDX_W-1:0] pidx;
  logic [KEY_W-1:0]  prod;
  logic [KEY_W-1:0]  dvd;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [KEY_W-1:0]  out_key;
  logic              out_hit;
  logic              out_last;

  logic [REM_W-1:0]     rem_step;
  logic [KEY_W-1:0]     dvd_step;
  logic [REM_W-1:0]     div_r;
  logic [KEY_W-1:0]     div_d;
  logic [MOD_W-1:0]     div_t;
  logic [ADDR_W-1:0]    word_addr;
  logic [BIT_SEL_W-1:0] bit_sel;
  logic [WORD_W-1:0]    bit_mask;
  logic [HIDX_W-1:0]    hidx_inc;
  logic                 last_hash;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [WORD_W-1:0] ram_rd_data;

  function automatic logic [MOD_W-1:0] sat_mod(input logic [CFG_BITS_W-1:0] fb);
    logic [CMP_W-1:0] v;
    v = CMP_W'(fb);
    if (v > CMP_W'(LIMIT)) v = CMP_W'(LIMIT);
    if (v == '0) v = CMP_W'(1);
    return MOD_W'(v);
  endfunction

  function automatic logic [HIDX_W-1:0] sat_hash(input logic [CFG_HASH_W-1:0] nh);
    int unsigned v;
    v = int'(nh);
    if (v > MAX_HASHES) v = MAX_HASHES;
    return HIDX_W'(v);
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(TDATA_OUT_W - KEY_W - 1){1'b0}}, out_hit, out_key};
  assign m_tlast   = out_last;

  // remainder: DIV_RADIX_BITS restoring steps per cycle
  always_comb begin
    div_r = rem;
    div_d = dvd;
    div_t = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      div_t = {div_r, div_d[KEY_W-1]};
      div_d = div_d << 1;
      if (div_t >= mod_eff) div_t = div_t - mod_eff;
      div_r = div_t[REM_W-1:0];
    end
    rem_step = div_r;
    dvd_step = div_d;
  end

  assign word_addr = ADDR_W'(rem >> BIT_SEL_W);
  assign bit_sel   = rem[BIT_SEL_W-1:0];
  assign bit_mask  = WORD_W'(1) << bit_sel;
  assign hidx_inc  = HIDX_W'(hidx + 1'b1);
  assign last_hash = (hidx_inc == nh_eff);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = word_addr;
    ram_wr_data = ram_rd_data | bit_mask;
    ram_rd_en   = (state == S_READ);
    if (state == S_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_cnt;
      ram_wr_data = '0;
    end else if (state == S_CHECK && cmd_r == CMD_INSERT) begin
      ram_wr_en = 1'b1;
    end
  end

  bfip_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FILTER_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (word_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      mod_eff  <= sat_mod(FILTER_BITS_RST);
      nh_eff   <= sat_hash(NUM_HASHES_RST);
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_FILTER_BITS) begin
          mod_eff <= sat_mod(CFG_BITS_W'(cfg_data));
        end else if (cfg_index == REG_NUM_HASHES) begin
          nh_eff <= sat_hash(CFG_HASH_W'(cfg_data));
        end
      end

      // S_DONE loads the output register itself
      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= ADDR_W'(clr_cnt + 1'b1);
          if (clr_cnt == ADDR_W'(FILTER_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            key_r   <= s_tdata[KEY_W-1:0];
            cmd_r   <= cmd_t'(s_tuser);
            last_r  <= s_tlast;
            all_set <= 1'b1;
            hidx    <= '0;
            pidx    <= '0;
            state   <= (nh_eff == '0) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          prod  <= key_r * KEY_W'(PRIMES[pidx]);
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          dvd   <= prod << 5'(hidx);
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_step;
          dvd  <= dvd_step;
          step <= STEP_W'(step + 1'b1);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          hidx <= hidx_inc;
          pidx <= (pidx == PIDX_W'(PRIME_COUNT - 1)) ? '0 : PIDX_W'(pidx + 1'b1);
          if (cmd_r == CMD_PROBE && !ram_rd_data[bit_sel]) begin
            all_set <= 1'b0;
            state   <= S_DONE;
          end else begin
            state <= last_hash ? S_DONE : S_MUL;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_key  <= key_r;
            out_hit  <= (cmd_r == CMD_PROBE) && all_set;
            out_last <= last_r;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/bfip_chk.sv */
// ----------------------------------------------------------------------------
// bfip_chk
// Port-level checks for the Bloom filter insert/probe block.
// ----------------------------------------------------------------------------
module bfip_chk
  import bfip_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [TDATA_IN_W-1:0]  s_tdata,
  input logic                   s_tlast,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [TDATA_OUT_W-1:0] m_tdata,
  input logic                   m_tlast,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_IDX_W-1:0]   cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  // clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !s_tready)
    else $error("request accepted during clearing pass");

  // input ready is low in the cycle after an accepted request
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a request");

  // a new result only follows a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind bloom_filter_insert_probe_top bfip_chk u_bfip_chk (.*);

/* sim/tb_bloom_filter_insert_probe_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_insert_probe_top
// Self-checking bench for the Bloom filter block. A local filter model
// predicts the hit flag of every request and keeps its own copy of the store.
// Directed requests cover the key extremes and the register corner cases.
// Random phases then mix inserts, probes of inserted keys and probes of fresh
// keys over several filter sizes. Both stream sides idle at random, and
// there are three long output stalls and drain pauses.
// ----------------------------------------------------------------------------
module tb_bloom_filter_insert_probe_top;
  import bfip_pkg::*;

  localparam int NUM_PRIMES = 15;
  localparam logic [31:0] HASH_PRIMES [NUM_PRIMES] = '{
    23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71, 73, 79, 83
  };
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = CFG_IDX_W'(255);
  localparam int STORE_BITS    = FILTER_WORDS * 32;
  localparam int HOLD_LEN      = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 280;
  localparam int CHUNK_ITEMS   = 40;
  localparam logic [CFG_DATA_W-1:0] PHASE_BITS [PHASES-1] = '{65536, 32, 1000, 257, 65536};
  localparam logic [CFG_DATA_W-1:0] PHASE_HASH [PHASES-1] = '{8, 1, 16, 17'h1FFE3, 16};

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] key;
    logic        last;
  } request_t;

  typedef struct packed {
    logic [31:0] key;
    logic        hit;
    logic        last;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;   // [31:0] key
  logic                   s_tlast = 1'b0; // batch_end
  logic                   s_tuser = 1'b0; // command
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;        // [31:0] key_out, [32] hit
  logic                   m_tlast;        // batch_end_out
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  request_t    request_queue [$];
  result_t     expected_results [$];
  logic [31:0] inserted_keys [$];

  logic [31:0]           filter_model [FILTER_WORDS];
  logic [CFG_BITS_W-1:0] model_filter_bits = FILTER_BITS_RST;
  logic [CFG_HASH_W-1:0] model_num_hashes  = NUM_HASHES_RST;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 65;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  int unsigned mismatches = 0;
  int unsigned inserts    = 0;
  int unsigned probes     = 0;
  int unsigned probe_hits = 0;
  int unsigned reg_writes = 0;

  bloom_filter_insert_probe_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    foreach (filter_model[w]) filter_model[w] = '0;
  end

  // Runs one request against the filter model, returns the hit flag.
  function automatic logic filter_lookup(input cmd_t cmd, input logic [31:0] key);
    logic [31:0] modulus;
    logic [31:0] hash;
    logic [31:0] pos;
    int unsigned hashes;
    logic        all_set;
    modulus = (model_filter_bits > STORE_BITS) ? 32'(STORE_BITS) : 32'(model_filter_bits);
    if (modulus == 0) modulus = 1;
    hashes  = (model_num_hashes > MAX_HASHES) ? MAX_HASHES : model_num_hashes;
    all_set = 1'b1;
    for (int unsigned i = 0; i < hashes; i++) begin
      hash = (key * HASH_PRIMES[i % NUM_PRIMES]) << i;
      pos  = hash % modulus;
      if (cmd == CMD_PROBE) begin
        if (!filter_model[pos >> 5][pos[4:0]]) begin
          all_set = 1'b0;
          break;
        end
      end else begin
        filter_model[pos >> 5][pos[4:0]] = 1'b1;
      end
    end
    return (cmd == CMD_PROBE) && all_set;
  endfunction

  function automatic logic [31:0] random_key();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_request(input cmd_t cmd, input logic [31:0] key, input logic last);
    request_queue.push_back('{cmd: cmd, key: key, last: last});
  endtask

  task automatic queue_random_request();
    int unsigned pick;
    logic [31:0] key;
    logic        last;
    pick = $urandom_range(99);
    last = ($urandom_range(7) == 0);
    if (pick < 45 || inserted_keys.size() == 0) begin
      key = random_key();
      inserted_keys.push_back(key);
      queue_request(CMD_INSERT, key, last);
    end else if (pick < 85) begin
      key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      queue_request(CMD_PROBE, key, last);
    end else begin
      queue_request(CMD_PROBE, random_key(), last);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == REG_FILTER_BITS) model_filter_bits = value;
    else if (idx == REG_NUM_HASHES) model_num_hashes = value[CFG_HASH_W-1:0];
  endtask

  // request driver
  always @(posedge clk) begin : sender
    request_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = request_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= req.key;
        s_tuser  <= req.cmd;
        s_tlast  <= req.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink, with the long hold-off counted here
  always @(posedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : scoreboard
    result_t want;
    logic    hit;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        hit = filter_lookup(cmd_t'(s_tuser), s_tdata);
        expected_results.push_back('{key: s_tdata, hit: hit, last: s_tlast});
        if (cmd_t'(s_tuser) == CMD_PROBE) begin
          probes++;
          if (hit) probe_hits++;
        end else begin
          inserts++;
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: key %h hit %0d last %0d",
                     m_tdata[31:0], m_tdata[32], m_tlast);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[31:0] !== want.key || m_tdata[32] !== want.hit || m_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected key %h hit %0d last %0d, got key %h hit %0d last %0d",
                       want.key, want.hit, want.last, m_tdata[31:0], m_tdata[32], m_tlast);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] bits_value;
    logic [CFG_DATA_W-1:0] hash_value;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // default filter: key extremes, hit and miss
    @(negedge clk);
    queue_request(CMD_INSERT, 32'h0000_0000, 1'b0);
    queue_request(CMD_PROBE,  32'h0000_0000, 1'b0);
    queue_request(CMD_PROBE,  32'hFFFF_FFFF, 1'b0);
    queue_request(CMD_INSERT, 32'hFFFF_FFFF, 1'b1);
    queue_request(CMD_PROBE,  32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // oversized modulus and hash count saturate; spare indexes ignored
    write_reg(REG_FILTER_BITS, 17'h1FFFF);
    write_reg(REG_NUM_HASHES, 17'd31);
    write_reg(REG_SPARE_LOW, 17'd5);
    write_reg(REG_SPARE_HIGH, 17'h1FFFF);
    @(negedge clk);
    queue_request(CMD_INSERT, 32'h1234_5678, 1'b0);
    queue_request(CMD_PROBE,  32'h1234_5678, 1'b1);
    queue_request(CMD_PROBE,  32'h8765_4321, 1'b0);
    wait_drained();

    // zero modulus: every hash lands on bit 0
    write_reg(REG_FILTER_BITS, 17'd0);
    write_reg(REG_NUM_HASHES, 17'd1);
    @(negedge clk);
    queue_request(CMD_INSERT, 32'hA5A5_A5A5, 1'b0);
    queue_request(CMD_PROBE,  32'h0000_0000, 1'b0);
    queue_request(CMD_PROBE,  32'h5A5A_5A5A, 1'b1);
    wait_drained();

    // no hashes: insert is a no-op, probe always hits
    write_reg(REG_NUM_HASHES, 17'd0);
    @(negedge clk);
    queue_request(CMD_PROBE,  32'hDEAD_BEEF, 1'b0);
    queue_request(CMD_INSERT, 32'hCAFE_F00D, 1'b1);
    wait_drained();

    // smallest filter, most hashes
    write_reg(REG_FILTER_BITS, 17'd32);
    write_reg(REG_NUM_HASHES, 17'd16);
    @(negedge clk);
    queue_request(CMD_INSERT, 32'h0000_0001, 1'b0);
    queue_request(CMD_PROBE,  32'h0000_0001, 1'b0);
    queue_request(CMD_PROBE,  32'h0000_0002, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES - 1) begin
        bits_value = PHASE_BITS[p];
        hash_value = PHASE_HASH[p];
      end else begin
        bits_value = CFG_DATA_W'($urandom_range(70000, 32));
        hash_value = CFG_DATA_W'($urandom_range(16, 1));
      end
      write_reg(REG_FILTER_BITS, bits_value);
      write_reg(REG_NUM_HASHES, hash_value);
      @(negedge clk);
      case (p / 2)
        0: begin send_idle_pct = 12; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int c = 0; c < PHASE_ITEMS / CHUNK_ITEMS; c++) begin
        repeat (CHUNK_ITEMS) queue_random_request();
        if (c == 2 && p % 2 == 0) hold_req++;
        do @(negedge clk); while (request_queue.size() != 0);
        if ($urandom_range(3) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (250) @(posedge clk);
    $display("Ran %0d inserts and %0d probes (%0d hits) over %0d register writes,",
             inserts, probes, probe_hits, reg_writes);
    $display("with saturated, zero and extreme filter settings; %0d mismatches.", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_bloom_filter_insert_probe_top OK");
    end else begin
      $display("tb_bloom_filter_insert_probe_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_bloom_filter_insert_probe_top NOT OK");
    $finish;
  end

endmodule
